/* design/rpn_stack_calculator_macros.svh */
// Assertion macros shared by the RPN stack calculator checkers.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn_stack_calculator: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn_stack_calculator: check failed");

`endif

/* design/rpn_pkg.sv */
// Types and constants shared by the RPN stack calculator modules.
package rpn_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 8;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_PEEK = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_START,
    S_CALC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    mode_t             op;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

/* design/rpn_if.sv */
// Valid/ready channel interfaces for commands and results.
interface rpn_in_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink   (input valid, input mode, input operand, output ready);
endinterface

interface rpn_out_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;

  modport source (output valid, output status, output top_value, output depth, input ready);
  modport sink   (input valid, input status, input top_value, input depth, output ready);
endinterface

/* design/rpn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/rpn_alu.sv */
// Shared iterative arithmetic unit: add/sub, shift-add multiply, restoring divide.
module rpn_alu import rpn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int ACC_W     = DATA_W + 2;
  localparam int DIV_STEPS = DATA_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  logic                  busy_r, busy_nxt;
  logic                  fin_r, fin_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  mode_t                 op_r, op_nxt;
  logic [DATA_W-1:0]     lv_r, lv_nxt;
  logic [DATA_W-1:0]     rv_r, rv_nxt;
  logic [ACC_W-1:0]      hi_r, hi_nxt;
  logic [2*DATA_W-1:0]   lo_r, lo_nxt;
  logic                  neg_r, neg_nxt;

  logic [ACC_W-1:0]      add_a, add_b, add_sum;
  logic                  add_cin;
  logic                  div_ge;
  logic [2*DATA_W-1:0]   prod, mag;
  logic                  mag_big;
  logic                  sat_pos, sat_neg;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

  // One adder serves every operation
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (op_r)
      MODE_ADD: begin
        add_a = {{2{lv_r[DATA_W-1]}}, lv_r};
        add_b = {{2{rv_r[DATA_W-1]}}, rv_r};
      end
      MODE_SUB: begin
        add_a   = {{2{lv_r[DATA_W-1]}}, lv_r};
        add_b   = ~{{2{rv_r[DATA_W-1]}}, rv_r};
        add_cin = 1'b1;
      end
      MODE_MUL: begin
        add_a = hi_r;
        add_b = lo_r[0] ? {2'b00, lv_r} : '0;
      end
      MODE_DIV: begin
        // partial remainder shifted left, next dividend bit in
        add_a   = {1'b0, hi_r[DATA_W-1:0], lo_r[2*DATA_W-1]};
        add_b   = ~{2'b00, rv_r};
        add_cin = 1'b1;
      end
      default: ;
    endcase
    add_sum = add_a + add_b + {{(ACC_W-1){1'b0}}, add_cin};
    div_ge  = !add_sum[ACC_W-1];
  end

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    steps_nxt = steps_r;
    op_nxt    = op_r;
    lv_nxt    = lv_r;
    rv_nxt    = rv_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    neg_nxt   = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      neg_nxt  = req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
      hi_nxt   = '0;
      unique case (req.op)
        MODE_MUL: begin
          steps_nxt = STEP_W'(DATA_W);
          lv_nxt    = mag32(req.lhs);
          rv_nxt    = mag32(req.rhs);
          lo_nxt    = {{DATA_W{1'b0}}, mag32(req.rhs)};
        end
        MODE_DIV: begin
          steps_nxt = STEP_W'(DIV_STEPS);
          lv_nxt    = mag32(req.lhs);
          rv_nxt    = mag32(req.rhs);
          lo_nxt    = {mag32(req.lhs), {DATA_W{1'b0}}};
        end
        default: begin
          steps_nxt = STEP_W'(1);
          lv_nxt    = req.lhs;
          rv_nxt    = req.rhs;
          lo_nxt    = '0;
        end
      endcase
    end else if (busy_r) begin
      steps_nxt = steps_r - STEP_W'(1);
      if (steps_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
      unique case (op_r)
        MODE_MUL: begin
          hi_nxt = {1'b0, add_sum[ACC_W-1:1]};
          lo_nxt = {{DATA_W{1'b0}}, add_sum[0], lo_r[DATA_W-1:1]};
        end
        MODE_DIV: begin
          hi_nxt = div_ge ? add_sum : add_a;
          lo_nxt = {lo_r[2*DATA_W-2:0], div_ge};
        end
        default: hi_nxt = add_sum;
      endcase
    end
  end

  // Final saturation, valid in the cycle after the last step
  always_comb begin
    prod    = {hi_r[DATA_W-1:0], lo_r[DATA_W-1:0]};
    mag     = (op_r == MODE_MUL) ? (prod >> FRAC_BITS) : lo_r;
    mag_big = |mag[2*DATA_W-1:DATA_W-1];
    sat_pos = !hi_r[ACC_W-1] && (hi_r[ACC_W-2] || hi_r[ACC_W-3]);
    sat_neg = hi_r[ACC_W-1] && !(hi_r[ACC_W-2] && hi_r[ACC_W-3]);
    rsp.done = fin_r;
    unique case (op_r)
      MODE_MUL, MODE_DIV: begin
        if (mag_big) begin
          rsp.result = neg_r ? SAT_MIN : SAT_MAX;
        end else begin
          rsp.result = neg_r ? (DATA_W'(0) - mag[DATA_W-1:0]) : mag[DATA_W-1:0];
        end
      end
      default: begin
        if (sat_pos) begin
          rsp.result = SAT_MAX;
        end else if (sat_neg) begin
          rsp.result = SAT_MIN;
        end else begin
          rsp.result = hi_r[DATA_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    op_r    <= op_nxt;
    lv_r    <= lv_nxt;
    rv_r    <= rv_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    neg_r   <= neg_nxt;
  end

endmodule

/* design/rpn_stack_calculator.sv */
// RPN operand stack with a shared iterative Q-format arithmetic unit.
// Each command on in_ch yields one result on out_ch (status, top of stack,
// depth). Push, peek, unused modes and every error case finish in the
// accept cycle and land in the output register. Arithmetic commands read
// the second operand from the stack RAM and then run on the shared adder,
// multiply and divide stepping one bit per cycle. The top of stack is held
// in a register, so only the second operand is read from the RAM. Failed
// commands leave the stack untouched. A new command is taken once the
// block is idle and the output register is free or being drained.
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 128,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   top_r, top_nxt;
  mode_t               op_r, op_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;

  mode_t               in_mode;
  logic                in_ready;
  logic                accept;
  logic                out_free;
  logic [CW-1:0]       cnt_m2;
  logic                full, two_plus, is_arith, go_arith;
  status_t             imm_status;
  logic [DATA_W-1:0]   imm_top;
  logic [CW-1:0]       imm_cnt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  assign in_mode  = mode_t'(in_ch.mode);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ready;
  assign cnt_m2   = cnt_r - CW'(2);
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign two_plus = (cnt_r >= CW'(2));
  assign is_arith = (in_mode == MODE_ADD) || (in_mode == MODE_SUB) ||
                    (in_mode == MODE_MUL) || (in_mode == MODE_DIV);
  assign go_arith = is_arith && two_plus && !((in_mode == MODE_DIV) && (top_r == '0));

  // Commands that complete in the accept cycle
  always_comb begin
    imm_status = ST_OK;
    imm_top    = (cnt_r != '0) ? top_r : '0;
    imm_cnt    = cnt_r;
    unique case (in_mode)
      MODE_PUSH: begin
        if (full) begin
          imm_status = ST_OVERFLOW;
        end else begin
          imm_top = in_ch.operand;
          imm_cnt = cnt_r + CW'(1);
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (!two_plus) begin
          imm_status = ST_UNDERFLOW;
        end else if (top_r == '0) begin
          imm_status = ST_DIV_ZERO;
        end
      end
      MODE_PEEK: begin
        if (cnt_r == '0) begin
          imm_status = ST_UNDERFLOW;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && go_arith) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_START;
      S_START: state_nxt = S_CALC;
      S_CALC:  if (alu_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    cnt_nxt        = cnt_r;
    top_nxt        = top_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = in_ch.operand;
    ram_re         = 1'b0;
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    alu_req.lhs    = ram_rdata;
    alu_req.rhs    = top_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_mode;
          if (!go_arith) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = imm_status;
            out_top_nxt    = imm_top;
            out_depth_nxt  = DEPTH_W'(imm_cnt);
            cnt_nxt        = imm_cnt;
            if ((in_mode == MODE_PUSH) && !full) begin
              ram_we  = 1'b1;
              top_nxt = in_ch.operand;
            end
          end
        end
      end
      S_FETCH: ram_re = 1'b1;
      S_START: alu_req.start = 1'b1;
      S_CALC: begin
        if (alu_rsp.done) begin
          // left operand slot takes the result, right operand is popped
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[AW-1:0];
          ram_wdata = alu_rsp.result;
          top_nxt   = alu_rsp.result;
          cnt_nxt   = cnt_r - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_top_nxt    = top_r;
          out_depth_nxt  = DEPTH_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  rpn_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    op_r         <= op_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.depth     = out_depth_r;

endmodule

/* design/rpn_checker.sv */
// Port-level checks for the RPN stack calculator, bound to the top level.
`include "rpn_stack_calculator_macros.svh"

module rpn_checker import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [DATA_W-1:0]   out_top_value,
  input logic [DEPTH_W-1:0]  out_depth
);

  // a stalled result holds
  `RPN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_top_value) && $stable(out_depth))

  // overflow only reported on a full stack
  `RPN_ASSERT_NOW(a_overflow_full, out_valid && (out_status == ST_OVERFLOW), out_depth == DEPTH_W'(STACK_DEPTH))

  // too few operands means at most one value held
  `RPN_ASSERT_NOW(a_underflow_depth, out_valid && (out_status == ST_UNDERFLOW), out_depth <= DEPTH_W'(1))

  // divide by zero leaves the zero divisor on top
  `RPN_ASSERT_NOW(a_divzero_top, out_valid && (out_status == ST_DIV_ZERO), out_top_value == '0)

endmodule

bind rpn_stack_calculator rpn_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_top_value (out_ch.top_value),
  .out_depth     (out_ch.depth)
);

/* sim/testbench.sv */
// Self-checking testbench for the RPN stack calculator: command stimulus, prediction, result checks.
`timescale 1ns / 100ps

module testbench import rpn_pkg::*; ();

  localparam int STACK_DEPTH = 128;
  localparam int FRAC_BITS   = 16;

  // unused command codes, the block must ignore them
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  depth;
  } calc_result_t;

  logic clk;
  logic rst_n;

  rpn_in_if  in_ch ();
  rpn_out_if out_ch ();

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the operand stack
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int                calc_count = 0;

  calc_result_t pending_results [$];
  int           fault_count = 0;
  bit           gaps_on     = 1'b1;
  bit           stalls_on   = 1'b1;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [DATA_W-1:0] clamp_wide(longint x);
    if (x > longint'($signed(SAT_MAX))) return SAT_MAX;
    if (x < longint'($signed(SAT_MIN))) return SAT_MIN;
    return x[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] clamp_mag(logic neg, logic [63:0] mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) return SAT_MIN;
      return '0 - mag[DATA_W-1:0];
    end
    if (mag > 64'h7FFF_FFFF) return SAT_MAX;
    return mag[DATA_W-1:0];
  endfunction

  function automatic logic [63:0] abs_wide(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // applies one command to the shadow stack and returns the expected result
  function automatic calc_result_t rpn_apply(logic [MODE_W-1:0] cmd, logic [DATA_W-1:0] operand);
    calc_result_t      res;
    longint            lhs;
    longint            rhs;
    logic              neg;
    logic [DATA_W-1:0] value;
    res.status = ST_OK;
    value = '0;
    case (cmd)
      MODE_PUSH: begin
        if (calc_count >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          calc_stack[calc_count] = operand;
          calc_count++;
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        if (calc_count < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          rhs = $signed(calc_stack[calc_count-1]);
          lhs = $signed(calc_stack[calc_count-2]);
          neg = (lhs < 0) != (rhs < 0);
          case (cmd)
            MODE_ADD: value = clamp_wide(lhs + rhs);
            MODE_SUB: value = clamp_wide(lhs - rhs);
            MODE_MUL: value = clamp_mag(neg, (abs_wide(lhs) * abs_wide(rhs)) >> FRAC_BITS);
            default: begin
              if (rhs == 0) res.status = ST_DIV_ZERO;
              else value = clamp_mag(neg, (abs_wide(lhs) << FRAC_BITS) / abs_wide(rhs));
            end
          endcase
          if (res.status == ST_OK) begin
            calc_count--;
            calc_stack[calc_count-1] = value;
          end
        end
      end
      MODE_PEEK: begin
        if (calc_count == 0) res.status = ST_UNDERFLOW;
      end
      default: ;
    endcase
    res.top_value = (calc_count > 0) ? calc_stack[calc_count-1] : '0;
    res.depth     = calc_count[DEPTH_W-1:0];
    return res;
  endfunction

  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // result checker and prediction on every command transfer
  always @(posedge clk) begin
    calc_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          log_fault($sformatf("result with nothing pending: status %0d top %h depth %0d",
                              out_ch.status, out_ch.top_value, out_ch.depth));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status || out_ch.top_value !== want.top_value ||
              out_ch.depth !== want.depth)
            log_fault($sformatf({"mismatch: expected status %0d top %h depth %0d,",
                                 " got status %0d top %h depth %0d"},
                                want.status, want.top_value, want.depth,
                                out_ch.status, out_ch.top_value, out_ch.depth));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(rpn_apply(in_ch.mode, in_ch.operand));
    end
  end

  // result side backpressure in random bursts
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 14);
        out_ch.ready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic issue_command(logic [MODE_W-1:0] cmd, logic [DATA_W-1:0] operand);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.mode    = cmd;
    in_ch.operand = operand;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = SAT_MAX;
      1: v = SAT_MIN;
      2: v = '0;
      3: v = $urandom_range(0, 20) << FRAC_BITS;
      4, 5: v = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [MODE_W-1:0] random_arith();
    return MODE_ADD + 3'($urandom_range(0, 3));
  endfunction

  // one command steered toward a target stack depth
  task automatic issue_random_command(int goal);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      issue_command($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, $urandom);
    else if (pick < 8)
      issue_command(MODE_PEEK, $urandom);
    else if (pick < 11)
      issue_command(random_arith(), $urandom);
    else if (calc_count < 2 || (calc_count < goal ? pick < 80 : pick < 30))
      issue_command(MODE_PUSH, random_operand());
    else
      issue_command(random_arith(), $urandom);
  endtask

  task automatic test_shallow_stack();
    issue_command(MODE_PEEK, '0);
    issue_command(MODE_ADD, '0);
    issue_command(MODE_DIV, '1);
    issue_command(MODE_PUSH, 32'h0001_0000);
    issue_command(MODE_SUB, '0);
    issue_command(MODE_MUL, '0);
    issue_command(MODE_PEEK, '1);
    issue_command(MODE_SPARE_A, 32'hFFFF_FFFF);
    issue_command(MODE_SPARE_B, '0);
  endtask

  task automatic test_arith_extremes();
    issue_command(MODE_PUSH, SAT_MAX);
    issue_command(MODE_ADD, '0);
    issue_command(MODE_PUSH, SAT_MIN);
    issue_command(MODE_SUB, '0);
    issue_command(MODE_PUSH, SAT_MIN);
    issue_command(MODE_MUL, '0);
    issue_command(MODE_PUSH, '0);
    issue_command(MODE_DIV, '0);     // divide by zero, both operands kept
    issue_command(MODE_MUL, '0);
    // product of tiny negative and one half truncates to zero
    issue_command(MODE_PUSH, 32'hFFFF_FFFF);
    issue_command(MODE_PUSH, 32'h0000_8000);
    issue_command(MODE_MUL, '0);
    issue_command(MODE_PUSH, SAT_MIN);
    issue_command(MODE_PUSH, 32'h0000_0001);
    issue_command(MODE_DIV, '0);
    issue_command(MODE_PUSH, 32'hFFFF_FFFF);
    issue_command(MODE_DIV, '0);
  endtask

  task automatic test_stack_full();
    while (calc_count < STACK_DEPTH) issue_command(MODE_PUSH, random_operand());
    repeat (3) issue_command(MODE_PUSH, random_operand());
    issue_command(MODE_PEEK, '0);
    while (calc_count > 1) issue_command(random_arith(), $urandom);
  endtask

  task automatic test_random_programs();
    int goal;
    for (int chunk = 0; chunk < 13; chunk++) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      goal = ($urandom_range(0, 3) == 0) ? $urandom_range(60, STACK_DEPTH)
                                         : $urandom_range(2, 10);
      repeat (100) issue_random_command(goal);
      if (chunk == 0 || $urandom_range(0, 3) == 0) wait_for_drain();
    end
  endtask

  task automatic test_quiet_tail();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (150) issue_random_command($urandom_range(2, 12));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_PUSH;
    in_ch.operand = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    test_shallow_stack();
    test_arith_extremes();
    test_stack_full();
    test_random_programs();
    test_quiet_tail();

    wait_for_drain();
    repeat (80) @(negedge clk);
    if (pending_results.size() != 0)
      log_fault($sformatf("%0d results never arrived", pending_results.size()));
    if (fault_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
